@@ design/xxh_pkg.sv @@
// xxh_pkg: shared types, constants and helpers of the xxh64 stream hash
// depends on nothing; used by xxh_ctrl, xxh_dpath, xxh64_stream_hash and the testbench
package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef enum logic [4:0] {
        OP_NOP, OP_BUF_WR, OP_T_ACC, OP_T_BUF, OP_T_LO32, OP_T_BYTE, OP_MUL,
        OP_RND_ACC, OP_RND_ZERO, OP_ACC_WR, OP_HXOR, OP_XROT, OP_H_ADDK,
        OP_H_ZERO, OP_H_SEED, OP_H_ROTACC, OP_H_LEN, OP_AV_A, OP_AV_B, OP_AV_C,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        K_ZERO, K_P1, K_P2, K_P3, K_P4, K_P5
    } t_ksel;

    typedef struct packed {
        t_op         op;
        t_ksel       ksel;
        logic [1:0]  ph;
        logic [1:0]  idx;
        logic [5:0]  rot;
    } t_cmd;

    typedef struct packed {
        logic [3:0] n;
        logic       last;
        logic [1:0] fill;
        logic       len_ge32;
        logic       out_busy;
    } t_stat;

    function automatic logic [63:0] kval(input t_ksel k);
        logic [63:0] v;
        case (k)
            K_P1:    v = P1;
            K_P2:    v = P2;
            K_P3:    v = P3;
            K_P4:    v = P4;
            K_P5:    v = P5;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] d;
        d = {x, x} << r;
        return d[127:64];
    endfunction

endpackage

@@ design/xxh_ctrl.sv @@
// xxh_ctrl: sequencer that walks each word through the hash datapath
// depends on xxh_pkg
module xxh_ctrl
    import xxh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_STRIPE, S_FIN, S_MSUM, S_MERGE, S_LEN, S_FOLD,
        S_TAIL, S_QUAD, S_BYTE, S_AVAL, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [1:0] r_idx, n_idx;
    logic [2:0] r_rem, n_rem;

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step + 4'd1;
        n_idx   = r_idx;
        n_rem   = r_rem;
        o_cmd   = '{op: OP_NOP, ksel: K_ZERO, ph: 2'd0, idx: r_idx, rot: 6'd0};
        case (r_state)
            S_IDLE: begin
                n_step = 4'd0;
                if (i_in_accept) n_state = S_DISP;
            end
            S_DISP: begin
                n_step = 4'd0;
                n_idx  = 2'd0;
                n_rem  = (i_stat.last && i_stat.n != FULL_BYTES) ? i_stat.n[2:0] : 3'd0;
                if (i_stat.n == FULL_BYTES) begin
                    if (i_stat.fill != 2'd3) begin
                        o_cmd.op = OP_BUF_WR;
                        n_state  = i_stat.last ? S_FIN : S_IDLE;
                    end else begin
                        n_state = S_STRIPE;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_STRIPE: begin
                case (r_step) inside
                    4'd0:         o_cmd.op = OP_T_BUF;
                    [4'd1:4'd3]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P2; o_cmd.ph = 2'(r_step - 4'd1);
                    end
                    4'd4:         o_cmd.op = OP_RND_ACC;
                    [4'd5:4'd7]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P1; o_cmd.ph = 2'(r_step - 4'd5);
                    end
                    default: begin
                        o_cmd.op = OP_ACC_WR;
                        n_step   = 4'd0;
                        if (r_idx == 2'd3) n_state = i_stat.last ? S_FIN : S_IDLE;
                        else n_idx = r_idx + 2'd1;
                    end
                endcase
            end
            S_FIN: begin
                n_idx  = 2'd0;
                n_step = 4'd0;
                if (i_stat.len_ge32) begin
                    o_cmd.op = OP_H_ZERO;
                    n_state  = S_MSUM;
                end else begin
                    o_cmd.op = OP_H_SEED;
                    n_state  = S_LEN;
                end
            end
            S_MSUM: begin
                o_cmd.op = OP_H_ROTACC;
                case (r_idx)
                    2'd0:    o_cmd.rot = 6'd1;
                    2'd1:    o_cmd.rot = 6'd7;
                    2'd2:    o_cmd.rot = 6'd12;
                    default: o_cmd.rot = 6'd18;
                endcase
                n_step = 4'd0;
                if (r_idx == 2'd3) begin
                    n_idx   = 2'd0;
                    n_state = S_MERGE;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            S_MERGE, S_FOLD: begin
                case (r_step) inside
                    4'd0: o_cmd.op = (r_state == S_MERGE) ? OP_T_ACC : OP_T_BUF;
                    [4'd1:4'd3]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P2; o_cmd.ph = 2'(r_step - 4'd1);
                    end
                    4'd4: o_cmd.op = OP_RND_ZERO;
                    [4'd5:4'd7]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P1; o_cmd.ph = 2'(r_step - 4'd5);
                    end
                    4'd8: begin
                        // merge xors plain, folding rotates the xor of hash and mixed value
                        o_cmd.op  = (r_state == S_MERGE) ? OP_HXOR : OP_XROT;
                        o_cmd.rot = 6'd27;
                    end
                    [4'd9:4'd11]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P1; o_cmd.ph = 2'(r_step - 4'd9);
                    end
                    default: begin
                        o_cmd.op   = OP_H_ADDK;
                        o_cmd.ksel = K_P4;
                        n_step     = 4'd0;
                        if (r_state == S_MERGE) begin
                            if (r_idx == 2'd3) n_state = S_LEN;
                            else n_idx = r_idx + 2'd1;
                        end else begin
                            if (r_idx == i_stat.fill - 2'd1) n_state = S_TAIL;
                            else n_idx = r_idx + 2'd1;
                        end
                    end
                endcase
            end
            S_LEN: begin
                o_cmd.op = OP_H_LEN;
                n_step   = 4'd0;
                n_idx    = 2'd0;
                n_state  = (i_stat.fill != 2'd0) ? S_FOLD : S_TAIL;
            end
            S_TAIL: begin
                n_step = 4'd0;
                if (r_rem >= 3'd4) n_state = S_QUAD;
                else if (r_rem != 3'd0) n_state = S_BYTE;
                else n_state = S_AVAL;
            end
            S_QUAD, S_BYTE: begin
                case (r_step) inside
                    4'd0: o_cmd.op = (r_state == S_QUAD) ? OP_T_LO32 : OP_T_BYTE;
                    [4'd1:4'd3]: begin
                        o_cmd.op   = OP_MUL;
                        o_cmd.ksel = (r_state == S_QUAD) ? K_P1 : K_P5;
                        o_cmd.ph   = 2'(r_step - 4'd1);
                    end
                    4'd4: begin
                        o_cmd.op  = OP_XROT;
                        o_cmd.rot = (r_state == S_QUAD) ? 6'd23 : 6'd11;
                    end
                    [4'd5:4'd7]: begin
                        o_cmd.op   = OP_MUL;
                        o_cmd.ksel = (r_state == S_QUAD) ? K_P2 : K_P1;
                        o_cmd.ph   = 2'(r_step - 4'd5);
                    end
                    default: begin
                        o_cmd.op   = OP_H_ADDK;
                        o_cmd.ksel = (r_state == S_QUAD) ? K_P3 : K_ZERO;
                        n_rem      = (r_state == S_QUAD) ? r_rem - 3'd4 : r_rem - 3'd1;
                        n_state    = S_TAIL;
                    end
                endcase
            end
            S_AVAL: begin
                case (r_step) inside
                    4'd0: o_cmd.op = OP_AV_A;
                    [4'd1:4'd3]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P2; o_cmd.ph = 2'(r_step - 4'd1);
                    end
                    4'd4: o_cmd.op = OP_AV_B;
                    [4'd5:4'd7]: begin
                        o_cmd.op = OP_MUL; o_cmd.ksel = K_P3; o_cmd.ph = 2'(r_step - 4'd5);
                    end
                    default: begin
                        o_cmd.op = OP_AV_C;
                        n_state  = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 4'd0;
            r_idx   <= 2'd0;
            r_rem   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ design/xxh_dpath.sv @@
// xxh_dpath: lane accumulators, stripe buffer, hash register and shared
// 32x32 multiplier; depends on xxh_pkg
module xxh_dpath
    import xxh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_in_accept,
    input  logic [63:0] i_word,
    input  logic [3:0]  i_count,
    input  logic        i_last,
    input  logic        i_cfg_wr,
    input  logic [63:0] i_cfg_data,
    input  logic        i_out_take,
    output t_stat       o_stat,
    output logic [63:0] o_digest,
    output logic        o_valid
);

    logic [63:0] r_acc [4];
    logic [63:0] r_buf [3];
    logic [1:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_seed;
    logic [63:0] r_w;
    logic [3:0]  r_n;
    logic        r_last;
    logic [63:0] r_t;
    logic [63:0] r_h;
    logic [63:0] r_p;
    logic [63:0] r_dig;
    logic        r_valid;

    logic [63:0] k;
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] prod;
    logic [63:0] src;
    logic [63:0] ht;
    logic [3:0]  n_cnt;

    always_comb begin
        k    = kval(i_cmd.ksel);
        m_a  = (i_cmd.ph == 2'd2) ? r_t[63:32] : r_t[31:0];
        m_b  = (i_cmd.ph == 2'd1) ? k[63:32] : k[31:0];
        prod = {32'd0, m_a} * {32'd0, m_b};
        // lane 3 of a stripe takes the incoming word
        src  = (i_cmd.idx == 2'd3) ? r_w : r_buf[i_cmd.idx];
        ht   = r_h ^ r_t;
        if (!i_last || i_count > FULL_BYTES) n_cnt = FULL_BYTES;
        else n_cnt = i_count;
    end

    assign o_stat = '{n: r_n, last: r_last, fill: r_fill,
                      len_ge32: (|r_len[63:5]), out_busy: r_valid};
    assign o_digest = r_dig;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= 64'd0;
            r_acc[0] <= P1 + P2;
            r_acc[1] <= P2;
            r_acc[2] <= 64'd0;
            r_acc[3] <= 64'd0 - P1;
            r_fill  <= 2'd0;
            r_len   <= 64'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_out_take) r_valid <= 1'b0;
            if (i_cfg_wr) begin
                r_seed   <= i_cfg_data;
                r_acc[0] <= i_cfg_data + P1 + P2;
                r_acc[1] <= i_cfg_data + P2;
                r_acc[2] <= i_cfg_data;
                r_acc[3] <= i_cfg_data - P1;
                r_fill   <= 2'd0;
                r_len    <= 64'd0;
            end
            if (i_in_accept) r_len <= r_len + {60'd0, n_cnt};
            case (i_cmd.op)
                OP_BUF_WR: begin
                    r_buf[r_fill] <= r_w;
                    r_fill        <= r_fill + 2'd1;
                end
                OP_ACC_WR: begin
                    r_acc[i_cmd.idx] <= r_t;
                    if (i_cmd.idx == 2'd3) r_fill <= 2'd0;
                end
                OP_EMIT: begin
                    r_dig    <= r_h;
                    r_valid  <= 1'b1;
                    r_acc[0] <= r_seed + P1 + P2;
                    r_acc[1] <= r_seed + P2;
                    r_acc[2] <= r_seed;
                    r_acc[3] <= r_seed - P1;
                    r_fill   <= 2'd0;
                    r_len    <= 64'd0;
                end
                default: ;
            endcase
        end
    end

    // payload registers and the working registers r_t, r_p and r_h
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_w    <= i_word;
            r_n    <= n_cnt;
            r_last <= i_last;
        end
        case (i_cmd.op)
            OP_T_ACC:    r_t <= r_acc[i_cmd.idx];
            OP_T_BUF:    r_t <= src;
            OP_T_LO32: begin
                r_t <= {32'd0, r_w[31:0]};
                r_w <= r_w >> 32;
            end
            OP_T_BYTE: begin
                r_t <= {56'd0, r_w[7:0]};
                r_w <= r_w >> 8;
            end
            OP_MUL: begin
                case (i_cmd.ph)
                    2'd0:    r_p <= prod;
                    2'd1:    r_p <= r_p + {prod[31:0], 32'd0};
                    default: r_t <= r_p + {prod[31:0], 32'd0};
                endcase
            end
            OP_RND_ACC:  r_t <= rotl64(r_acc[i_cmd.idx] + r_t, 6'd31);
            OP_RND_ZERO: r_t <= rotl64(r_t, 6'd31);
            OP_HXOR:     r_t <= ht;
            OP_XROT:     r_t <= rotl64(ht, i_cmd.rot);
            OP_H_ADDK:   r_h <= r_t + k;
            OP_H_ZERO:   r_h <= 64'd0;
            OP_H_SEED:   r_h <= r_seed + P5;
            OP_H_ROTACC: r_h <= r_h + rotl64(r_acc[i_cmd.idx], i_cmd.rot);
            OP_H_LEN:    r_h <= r_h + r_len;
            OP_AV_A:     r_t <= r_h ^ (r_h >> 33);
            OP_AV_B:     r_t <= r_t ^ (r_t >> 29);
            OP_AV_C:     r_h <= r_t ^ (r_t >> 32);
            default: ;
        endcase
    end

endmodule

@@ design/xxh64_stream_hash.sv @@
// xxh64_stream_hash: top level of the 64-bit xxhash over a word stream
// depends on xxh_pkg, xxh_ctrl and xxh_dpath
//
// channel   dir  handshake             payload
// s (words) in   i_s_tvalid/o_s_tready i_s_tdata {byte_count, data_word}, i_s_tlast
// m (hash)  out  o_m_tvalid/i_m_tready o_m_tdata digest
// cfg seed  in   i_cfg_valid/o_cfg_ready i_cfg_data hash_seed
//
// a word that only fills the stripe buffer is written there; the word that
// completes a stripe runs four lane rounds, one per lane accumulator
// every 64-bit multiply runs as three 32x32 partial products on one shared
// multiplier; the final word runs the lane merge only at or above 32 bytes,
// then folds each buffered word, any 4-byte tail piece and each trailing byte
// synchronous active-low reset; the digest sits in an output register and the
// next message is taken while it waits; the sequencer stalls before emitting
// only if the previous digest has not yet been taken
module xxh64_stream_hash
    import xxh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [63:0] data_word, [67:64] byte_count, rest zero
    input  logic        i_s_tlast,   // last_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] digest
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data   // hash_seed
);

    t_cmd  cmd;
    t_stat stat;
    logic  idle;
    logic  in_accept;
    logic  cfg_wr;
    logic  out_take;

    // a seed write wins over a word arriving in the same cycle
    assign o_cfg_ready = idle;
    assign o_s_tready  = idle & ~i_cfg_valid;
    assign in_accept   = i_s_tvalid & o_s_tready;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign out_take    = o_m_tvalid & i_m_tready;

    xxh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_idle      (idle)
    );

    xxh_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_accept(in_accept),
        .i_word     (i_s_tdata[63:0]),
        .i_count    (i_s_tdata[67:64]),
        .i_last     (i_s_tlast),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_out_take (out_take),
        .o_stat     (stat),
        .o_digest   (o_m_tdata),
        .o_valid    (o_m_tvalid)
    );

endmodule

@@ dv/xxh64_stream_hash_test.sv @@
`timescale 1ns / 100ps
// xxh64_stream_hash_test: self-checking testbench of the xxh64 stream hash
// depends on xxh_pkg and xxh64_stream_hash; directed table, then random messages
module xxh64_stream_hash_test
    import xxh_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;    // [63:0] data_word, [67:64] byte_count, rest zero
    logic        i_s_tlast;    // last_word
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;    // [63:0] digest
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;   // hash_seed

    xxh64_stream_hash dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // cycles to let pass before a seed write; covers a stripe round and a full
    // finalization with three buffered words and a tail
    localparam int SETTLE_CYCLES = 400;
    // long receiver hold-off, so the output register fills and input stalls
    localparam int HOLD_CYCLES   = 3000;
    localparam logic [63:0] EMPTY_DIGEST_SEED0 = 64'hEF46DB3751D8E999;

    // shadow of the hash state
    logic [63:0] seed_q;
    logic [63:0] lane_q [4];
    logic [63:0] stripe_buf_q [3];
    int unsigned stripe_cnt_q;
    logic [63:0] msg_len_q;

    logic [63:0] digest_queue [$];
    int unsigned error_count = 0;
    int unsigned digests_seen = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
        logic [63:0] a;
        a = acc + w * P2;
        return rotl(a, 31) * P1;
    endfunction

    function automatic void restart_hash();
        lane_q[0]    = seed_q + P1 + P2;
        lane_q[1]    = seed_q + P2;
        lane_q[2]    = seed_q;
        lane_q[3]    = seed_q - P1;
        stripe_cnt_q = 0;
        msg_len_q    = '0;
    endfunction

    function automatic void absorb_word(input logic [63:0] w);
        if (stripe_cnt_q < 3) begin
            stripe_buf_q[stripe_cnt_q] = w;
            stripe_cnt_q++;
        end else begin
            lane_q[0] = lane_mix(lane_q[0], stripe_buf_q[0]);
            lane_q[1] = lane_mix(lane_q[1], stripe_buf_q[1]);
            lane_q[2] = lane_mix(lane_q[2], stripe_buf_q[2]);
            lane_q[3] = lane_mix(lane_q[3], w);
            stripe_cnt_q = 0;
        end
    endfunction

    // digest prediction for one accepted word; queues a digest on a last word
    function automatic void predict_digest(input logic [63:0] word, input logic [3:0] cnt,
                                           input logic last);
        logic [63:0] h;
        logic [63:0] w;
        int unsigned n;
        w = word;
        n = cnt;
        if (!last || n > 8) n = 8;
        msg_len_q += n;
        if (!last) begin
            absorb_word(w);
            return;
        end
        if (n == 8) begin
            absorb_word(w);
            n = 0;
            w = '0;
        end
        if (msg_len_q >= 32) begin
            h = rotl(lane_q[0], 1) + rotl(lane_q[1], 7) + rotl(lane_q[2], 12)
              + rotl(lane_q[3], 18);
            for (int k = 0; k < 4; k++) begin
                h ^= lane_mix('0, lane_q[k]);
                h = h * P1 + P4;
            end
        end else begin
            h = seed_q + P5;
        end
        h += msg_len_q;
        for (int k = 0; k < stripe_cnt_q; k++) begin
            h ^= lane_mix('0, stripe_buf_q[k]);
            h = rotl(h, 27) * P1 + P4;
        end
        if (n >= 4) begin
            h ^= {32'd0, w[31:0]} * P1;
            h = rotl(h, 23) * P2 + P3;
            w = w >> 32;
            n -= 4;
        end
        while (n > 0) begin
            h ^= {56'd0, w[7:0]} * P5;
            h = rotl(h, 11) * P1;
            w = w >> 8;
            n--;
        end
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;
        digest_queue.push_back(h);
        restart_hash();
    endfunction

    // ---------------------------------------------------------------- sender
    int unsigned burst_left;

    // one word transaction; ready is sampled at the falling edge before the
    // rising edge that takes the word
    task automatic send_word(input logic [63:0] word, input logic [3:0] cnt, input logic last);
        bit          rdy;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, cnt, word};
        i_s_tlast  <= last;
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
        end while (!rdy);
        predict_digest(word, cnt, last);
    endtask

    task automatic idle_sender();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // seed write, only once every digest is in and the block has settled
    task automatic write_seed(input logic [63:0] seed);
        bit rdy;
        i_s_tvalid <= 1'b0;
        wait (digest_queue.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        seed_q = seed;
        restart_hash();
    endtask

    // random message: mostly well-formed, some with odd counts on inner words
    task automatic send_message(inout int unsigned words_sent);
        int unsigned nwords;
        logic [3:0]  cnt;
        nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        for (int k = 0; k < nwords; k++) begin
            cnt = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15)) : FULL_BYTES;
            send_word({$urandom, $urandom}, cnt, 1'b0);
            words_sent++;
        end
        cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        send_word({$urandom, $urandom}, cnt, 1'b1);
        words_sent++;
    endtask

    // ---------------------------------------------------------------- receiver
    logic [15:0] stall_pattern;
    int unsigned rx_cycle;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready    <= 1'b0;
            rx_cycle      <= 0;
            stall_pattern <= 16'hFFFF;
        end else if (!hold_done && digests_seen == 40) begin
            // long hold-off while the sender keeps offering words
            i_m_tready <= 1'b0;
            hold_done  <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
        end else begin
            if (rx_cycle[7:0] == 8'd0)
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            i_m_tready <= stall_pattern[rx_cycle[3:0]];
            rx_cycle   <= rx_cycle + 1;
        end
    end

    // ready only moves at the rising edge, so the falling edge sees the
    // value the next rising edge will use
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            digests_seen++;
            if (digest_queue.size() == 0) begin
                $error("digest transaction with none expected: actual %h", o_m_tdata);
                error_count++;
            end else begin
                logic [63:0] exp_digest;
                exp_digest = digest_queue.pop_front();
                if (o_m_tdata !== exp_digest) begin
                    $error("digest mismatch: expected %h actual %h", exp_digest, o_m_tdata);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- directed table
    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
        bit          known;      // digest typed in below
        logic [63:0] digest;
    } t_dir_row;

    t_dir_row dir_rows [] = '{
        // empty message at seed zero
        '{64'h0123456789ABCDEF, 4'd0,  1'b1, 1'b1, EMPTY_DIGEST_SEED0},
        // one byte, four bytes, seven bytes; high bytes are junk
        '{64'hFFFFFFFFFFFFFFFF, 4'd1,  1'b1, 1'b0, '0},
        '{64'hA5A5A5A5FFFFFFFF, 4'd4,  1'b1, 1'b0, '0},
        '{64'hEE00000000000000, 4'd7,  1'b1, 1'b0, '0},
        // count above eight on the last word saturates
        '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 1'b0, '0},
        // zero count on an inner word counts as eight
        '{64'h0000000000000000, 4'd0,  1'b0, 1'b0, '0},
        '{64'h8000000000000001, 4'd8,  1'b1, 1'b0, '0},
        // full stripe plus five-byte tail: merge path, 4-byte and byte folds
        '{64'hFFFFFFFFFFFFFFFF, 4'd8,  1'b0, 1'b0, '0},
        '{64'h0000000000000000, 4'd3,  1'b0, 1'b0, '0},
        '{64'h5555555555555555, 4'd8,  1'b0, 1'b0, '0},
        '{64'hAAAAAAAAAAAAAAAA, 4'd8,  1'b0, 1'b0, '0},
        '{64'hFFFFFF1122334455, 4'd5,  1'b1, 1'b0, '0},
        // exactly 32 bytes
        '{64'h0706050403020100, 4'd8,  1'b0, 1'b0, '0},
        '{64'h0F0E0D0C0B0A0908, 4'd8,  1'b0, 1'b0, '0},
        '{64'h1716151413121110, 4'd8,  1'b0, 1'b0, '0},
        '{64'h1F1E1D1C1B1A1918, 4'd8,  1'b1, 1'b0, '0}
    };

    logic [63:0] phase_seeds [5] = '{64'hFFFFFFFFFFFFFFFF, 64'd1, 64'd0,
                                    64'h8000000000000000, 64'hDEADBEEFCAFEF00D};

    // ---------------------------------------------------------------- main flow
    initial begin
        int unsigned words_sent;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        burst_left  = 0;
        words_sent  = 0;
        seed_q      = '0;
        stripe_buf_q = '{default: '0};
        restart_hash();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_seed(64'd0);
        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].word, dir_rows[r].cnt, dir_rows[r].last);
            // overwrite the prediction with the typed value where there is one
            if (dir_rows[r].known)
                digest_queue[digest_queue.size() - 1] = dir_rows[r].digest;
        end

        foreach (phase_seeds[p]) begin
            write_seed(p == 4 ? {$urandom, $urandom} : phase_seeds[p]);
            while (words_sent < (p + 1) * 290)
                send_message(words_sent);
            // a partial message left open before the next seed write
            if (p == 2)
                send_word({$urandom, $urandom}, FULL_BYTES, 1'b0);
        end
        idle_sender();

        wait (digest_queue.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/xxh_pkg.sv
design/xxh_ctrl.sv
design/xxh_dpath.sv
design/xxh64_stream_hash.sv
dv/xxh64_stream_hash_test.sv
